/* rtl/core/dhb_pkg.sv */
// ----------------------------------------------------------------------------
// dhb_pkg
// Shared types and constants for the dual H-bridge PWM driver.
// ----------------------------------------------------------------------------
package dhb_pkg;

  // Command codes of an input item
  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_SET_DIR   = 2'd1,
    CMD_TOGGLE    = 2'd2,
    CMD_SET_RATIO = 2'd3
  } cmd_t;

  // Number of motor slots on the result item
  localparam int MAX_MOTORS = 2;

  // Full scale of the duty ratio, the bits to hold it, and the ratio input width
  localparam int PCT_FULL = 100;
  localparam int PCT_BITS = 7;
  localparam int RATIO_W  = 8;

  // Reset value of the period top register
  localparam logic [15:0] PERIOD_RESET = 16'd1000;

  // Per-motor decoded command for one accepted item
  typedef struct packed {
    logic tick;
    logic wrap;
    logic set_dir;
    logic toggle;
    logic set_ratio;
    logic direction;
  } motor_cmd_t;

  // Result item payload
  typedef struct packed {
    logic motor0_pin_a;
    logic motor0_pin_b;
    logic motor1_pin_a;
    logic motor1_pin_b;
    logic period_start;
  } res_t;

endpackage

/* rtl/core/dhb_if.sv */
// ----------------------------------------------------------------------------
// dhb_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface dhb_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic       motor;
  logic       direction;
  logic [7:0] ratio;

  modport source (output valid, output command, output motor, output direction,
                  output ratio, input ready);
  modport sink   (input valid, input command, input motor, input direction,
                  input ratio, output ready);
endinterface

interface dhb_res_if;
  logic valid;
  logic ready;
  logic motor0_pin_a;
  logic motor0_pin_b;
  logic motor1_pin_a;
  logic motor1_pin_b;
  logic period_start;

  modport source (output valid, output motor0_pin_a, output motor0_pin_b,
                  output motor1_pin_a, output motor1_pin_b, output period_start,
                  input ready);
  modport sink   (input valid, input motor0_pin_a, input motor0_pin_b,
                  input motor1_pin_a, input motor1_pin_b, input period_start,
                  output ready);
endinterface

/* rtl/core/dhb_motor.sv */
// ----------------------------------------------------------------------------
// dhb_motor
// State and pin logic of one H-bridge: direction select, fixed or PWM drive.
// ----------------------------------------------------------------------------
module dhb_motor #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       en,
  input  dhb_pkg::motor_cmd_t                        mcmd,
  input  logic [dhb_pkg::RATIO_W-1:0]                ratio,
  input  logic [COUNT_WIDTH-1:0]                     top,
  input  logic [COUNT_WIDTH+dhb_pkg::PCT_BITS-1:0]   cnt_lo,
  input  logic [COUNT_WIDTH+dhb_pkg::PCT_BITS-1:0]   cnt_hi,
  output logic                                       pin_a,
  output logic                                       pin_b
);
  import dhb_pkg::*;

  localparam int PW = COUNT_WIDTH + PCT_BITS;

  // The compare point is held as top * ratio; the counter hits it when
  // 100 * counter <= product < 100 * counter + 100.
  logic          selected_pin, selected_pin_next;
  logic          fixed_mode, fixed_mode_next;
  logic          fixed_level, fixed_level_next;
  logic          pwm_level, pwm_level_next;
  logic [PW-1:0] cmp_prod, cmp_prod_next;

  logic [PCT_BITS-1:0] sat;
  logic                hit;
  logic                lvl;

  // Saturate the ratio to full scale
  assign sat = (ratio > RATIO_W'(PCT_FULL)) ? PCT_BITS'(PCT_FULL) : ratio[PCT_BITS-1:0];
  assign hit = (cnt_lo <= cmp_prod) && (cmp_prod < cnt_hi);

  // Next state
  always_comb begin
    selected_pin_next = selected_pin;
    fixed_mode_next   = fixed_mode;
    fixed_level_next  = fixed_level;
    pwm_level_next    = pwm_level;
    cmp_prod_next     = cmp_prod;
    if (mcmd.tick) begin
      if (!fixed_mode) begin
        if (mcmd.wrap) pwm_level_next = 1'b1;
        if (hit) pwm_level_next = 1'b0;
      end
    end else if (mcmd.set_dir || mcmd.toggle) begin
      selected_pin_next = mcmd.set_dir ? mcmd.direction : ~selected_pin;
      if (!fixed_mode) pwm_level_next = 1'b0;
    end else if (mcmd.set_ratio) begin
      if (sat == '0 || sat == PCT_BITS'(PCT_FULL)) begin
        fixed_mode_next  = 1'b1;
        fixed_level_next = (sat == PCT_BITS'(PCT_FULL));
      end else begin
        if (fixed_mode) pwm_level_next = fixed_level;
        fixed_mode_next = 1'b0;
        cmp_prod_next   = PW'(top) * PW'(sat);
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      selected_pin <= 1'b0;
      fixed_mode   <= 1'b1;
      fixed_level  <= 1'b0;
      pwm_level    <= 1'b0;
      cmp_prod     <= '0;
    end else if (en) begin
      selected_pin <= selected_pin_next;
      fixed_mode   <= fixed_mode_next;
      fixed_level  <= fixed_level_next;
      pwm_level    <= pwm_level_next;
      cmp_prod     <= cmp_prod_next;
    end
  end

  // Pin levels after this item
  assign lvl   = fixed_mode_next ? fixed_level_next : pwm_level_next;
  assign pin_a = !selected_pin_next && lvl;
  assign pin_b = selected_pin_next && lvl;

endmodule

/* rtl/core/dhb_res_buf.sv */
// ----------------------------------------------------------------------------
// dhb_res_buf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module dhb_res_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  dhb_pkg::res_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output dhb_pkg::res_t out_data
);
  import dhb_pkg::*;

  logic main_valid;
  logic skid_valid;
  res_t main_data;
  res_t skid_data;

  assign in_ready  = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !main_valid) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= in_valid;
      end
    end else if (in_valid && in_ready) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (out_ready || !main_valid) begin
      main_data <= skid_valid ? skid_data : in_data;
    end else if (in_valid && in_ready) begin
      skid_data <= in_data;
    end
  end

endmodule

/* rtl/core/dual_h_bridge_pwm_driver_top.sv */
// ----------------------------------------------------------------------------
// dual_h_bridge_pwm_driver_top
// Two H-bridge PWM drivers sharing one period counter, one result per item.
// ----------------------------------------------------------------------------
// Result: an item's result is registered in the output or the skid register.
// Throughput: one item per cycle; the two-entry result buffer keeps taking
//   items while one result waits, and stalls input only when both are full.
// Reset: synchronous; clears the counter and motor state (fixed drive, low,
//   first pin), empties the result buffer, and sets the period top to 1000.
module dual_h_bridge_pwm_driver_top #(
  parameter int MOTOR_COUNT = 2,
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  dhb_cmd_if.sink     cmd,
  dhb_res_if.source   res,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import dhb_pkg::*;

  localparam int PW = COUNT_WIDTH + PCT_BITS;

  logic [15:0]            period_counts;
  logic [COUNT_WIDTH-1:0] period_counter, period_counter_next;
  logic [COUNT_WIDTH-1:0] top;
  logic                   accept;
  logic                   in_ready;
  logic                   is_tick;
  logic                   wrap;
  logic [PW-1:0]          cnt_lo, cnt_hi;
  logic [MAX_MOTORS-1:0]  pa, pb;
  cmd_t                   op;
  res_t                   res_item;
  res_t                   res_out;

  assign cmd.ready = in_ready;
  assign accept    = cmd.valid && in_ready;
  assign op        = cmd_t'(cmd.command);
  assign top       = period_counts[COUNT_WIDTH-1:0];
  assign is_tick   = (op == CMD_TICK);

  // Period top register
  always_ff @(posedge clk) begin
    if (rst) begin
      period_counts <= PERIOD_RESET;
    end else if (cfg_we) begin
      period_counts <= cfg_wdata;
    end
  end

  // Shared period counter
  assign wrap = is_tick && (period_counter >= top);
  always_comb begin
    period_counter_next = period_counter;
    if (is_tick) begin
      period_counter_next = wrap ? '0 : period_counter + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_counter <= '0;
    end else if (accept) begin
      period_counter <= period_counter_next;
    end
  end

  // Scaled counter window for the compare test
  assign cnt_lo = PW'(period_counter_next) * PW'(PCT_FULL);
  assign cnt_hi = cnt_lo + PW'(PCT_FULL);

  // Motor slots; an absent motor ignores commands and reads low
  for (genvar k = 0; k < MAX_MOTORS; k++) begin : g_motor
    if (k < MOTOR_COUNT) begin : g_on
      motor_cmd_t mcmd;
      logic       addr;
      assign addr           = (cmd.motor == 1'(k));
      assign mcmd.tick      = is_tick;
      assign mcmd.wrap      = wrap;
      assign mcmd.set_dir   = addr && (op == CMD_SET_DIR);
      assign mcmd.toggle    = addr && (op == CMD_TOGGLE);
      assign mcmd.set_ratio = addr && (op == CMD_SET_RATIO);
      assign mcmd.direction = cmd.direction;

      dhb_motor #(
        .COUNT_WIDTH(COUNT_WIDTH)
      ) u_motor (
        .clk    (clk),
        .rst    (rst),
        .en     (accept),
        .mcmd   (mcmd),
        .ratio  (cmd.ratio),
        .top    (top),
        .cnt_lo (cnt_lo),
        .cnt_hi (cnt_hi),
        .pin_a  (pa[k]),
        .pin_b  (pb[k])
      );
    end else begin : g_off
      assign pa[k] = 1'b0;
      assign pb[k] = 1'b0;
    end
  end

  // Result item
  assign res_item.motor0_pin_a = pa[0];
  assign res_item.motor0_pin_b = pb[0];
  assign res_item.motor1_pin_a = pa[1];
  assign res_item.motor1_pin_b = pb[1];
  assign res_item.period_start = wrap;

  dhb_res_buf u_res_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (in_ready),
    .in_data   (res_item),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_data  (res_out)
  );

  assign res.motor0_pin_a = res_out.motor0_pin_a;
  assign res.motor0_pin_b = res_out.motor0_pin_b;
  assign res.motor1_pin_a = res_out.motor1_pin_a;
  assign res.motor1_pin_b = res_out.motor1_pin_b;
  assign res.period_start = res_out.period_start;

endmodule
